// ===== rtl/fpr_pkg.sv =====
package fpr_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CRC_LO  = 2'd2,
        PH_CRC_HI  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_START = 2'd1,
        ST_BAD_LEN   = 2'd2,
        ST_BAD_CRC   = 2'd3
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef enum logic {
        REG_START_BYTE = 1'b0,
        REG_MAX_LEN    = 1'b1
    } reg_index_t;

    localparam int unsigned LenWidth    = 10;
    localparam int unsigned HdrLastByte = 2;

    localparam logic [7:0]          StartByteReset = 8'd170;
    localparam logic [LenWidth-1:0] MaxLenReset    = 10'd415;

    typedef struct packed {
        kind_t               kind;
        logic [7:0]          payload_byte;
        status_t             frame_status;
        logic [LenWidth-1:0] frame_length;
        logic                write_flag;
    } result_t;

    // CRC-16/XMODEM, one byte per call
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] t;
        t = {8'd0, crc[15:8] ^ b};
        t = t ^ (t >> 4);
        return (crc << 8) ^ t ^ (t << 5) ^ (t << 12);
    endfunction

endpackage

// ===== rtl/framed_packet_receiver.sv =====
// Framed packet receiver.
// Input stream (s_*): one received serial byte per request in s_tdata.
// Output stream (m_*): zero or one result per input byte. m_tuser = 0 marks a
// payload byte passed through, m_tuser = 1 an end-of-frame status
// (ok, bad start byte, bad length, CRC mismatch) with the decoded length and
// write flag. Frame: start byte, 16-bit little-endian header, payload, CRC-16
// (poly 0x1021, init 0) low byte first, covering everything before it.
// Results are registered in the output register, or the skid entry if stalled.
// Throughput: one byte per cycle while s_tready is high; the byte-wise CRC
// update and phase logic sit between the state and two-entry output registers.
// Stall: when m_tready is low the output register holds its result and a
// skid entry takes one more; s_tready drops only once the skid entry is full.
// Reset (aresetn low, synchronous): phase back to header hunt, CRC and
// counters cleared, output empty, registers to start byte 0xAA and a
// maximum payload length of 415.
// APB: start_byte at 0x0, max_payload_length at 0x4; write only when idle.
module framed_packet_receiver (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] payload_byte, [9:8] frame_status,
                                   // [19:10] frame_length, [20] write_flag
    output logic        m_tuser,   // [0] result_kind

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned LW = fpr_pkg::LenWidth;

    // configuration
    logic [7:0]    start_byte_reg;
    logic [LW-1:0] max_len_reg;

    // deframer state
    fpr_pkg::phase_t phase_reg, phase_next;
    logic [LW-1:0]   cnt_reg, cnt_next;
    logic [15:0]     crc_reg, crc_next;
    logic [7:0]      first_reg, first_next;
    logic [7:0]      hdr_lo_reg, hdr_lo_next;
    logic [LW-1:0]   len_reg, len_next;
    logic            rw_reg, rw_next;
    logic [7:0]      crc_lo_reg, crc_lo_next;

    // output queue
    fpr_pkg::result_t out_reg, out_next, skid_reg, res;
    logic             out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;

    logic            s_accept, m_pop, push;
    logic [15:0]     crc_upd;
    logic [LW-1:0]   len_hdr, cnt_inc;
    logic            cfg_wr;
    fpr_pkg::reg_index_t cfg_idx;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign cfg_idx  = fpr_pkg::reg_index_t'(paddr[2]);
    assign prdata   = (cfg_idx == fpr_pkg::REG_MAX_LEN) ? {{(32-LW){1'b0}}, max_len_reg}
                                                        : {24'd0, start_byte_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= fpr_pkg::StartByteReset;
            max_len_reg    <= fpr_pkg::MaxLenReset;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                fpr_pkg::REG_START_BYTE: start_byte_reg <= pwdata[7:0];
                fpr_pkg::REG_MAX_LEN:    max_len_reg    <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = ~skid_valid_reg;
    assign s_accept = s_tvalid & s_tready;
    assign m_pop    = out_valid_reg & m_tready;

    // header phase restarts the CRC on the first byte
    assign crc_upd  = fpr_pkg::crc16_byte((phase_reg == fpr_pkg::PH_HEADER && cnt_reg == '0)
                                          ? 16'd0 : crc_reg, s_tdata);
    assign len_hdr  = {s_tdata, hdr_lo_reg[7:6]};
    assign cnt_inc  = cnt_reg + 1'b1;

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        crc_next    = crc_reg;
        first_next  = first_reg;
        hdr_lo_next = hdr_lo_reg;
        len_next    = len_reg;
        rw_next     = rw_reg;
        crc_lo_next = crc_lo_reg;
        push        = 1'b0;
        res.kind         = fpr_pkg::KIND_STATUS;
        res.payload_byte = 8'd0;
        res.frame_status = fpr_pkg::ST_OK;
        res.frame_length = len_reg;
        res.write_flag   = rw_reg;

        if (s_accept) begin
            unique case (phase_reg)
                fpr_pkg::PH_HEADER: begin
                    crc_next = crc_upd;
                    if (cnt_reg == '0) begin
                        first_next = s_tdata;
                    end
                    if (cnt_reg == LW'(1)) begin
                        hdr_lo_next = s_tdata;
                    end
                    if (cnt_reg < LW'(fpr_pkg::HdrLastByte)) begin
                        cnt_next = cnt_inc;
                    end else begin
                        cnt_next         = '0;
                        len_next         = len_hdr;
                        rw_next          = hdr_lo_reg[0];
                        res.frame_length = len_hdr;
                        res.write_flag   = hdr_lo_reg[0];
                        if (first_reg != start_byte_reg) begin
                            push             = 1'b1;
                            res.frame_status = fpr_pkg::ST_BAD_START;
                        end else if (len_hdr == '0 || len_hdr > max_len_reg) begin
                            push             = 1'b1;
                            res.frame_status = fpr_pkg::ST_BAD_LEN;
                        end else begin
                            phase_next = fpr_pkg::PH_PAYLOAD;
                        end
                    end
                end
                fpr_pkg::PH_PAYLOAD: begin
                    crc_next         = crc_upd;
                    cnt_next         = cnt_inc;
                    if (cnt_inc >= len_reg) begin
                        cnt_next   = '0;
                        phase_next = fpr_pkg::PH_CRC_LO;
                    end
                    push             = 1'b1;
                    res.kind         = fpr_pkg::KIND_PAYLOAD;
                    res.payload_byte = s_tdata;
                end
                fpr_pkg::PH_CRC_LO: begin
                    crc_lo_next = s_tdata;
                    phase_next  = fpr_pkg::PH_CRC_HI;
                end
                fpr_pkg::PH_CRC_HI: begin
                    phase_next       = fpr_pkg::PH_HEADER;
                    cnt_next         = '0;
                    push             = 1'b1;
                    res.frame_status = ({s_tdata, crc_lo_reg} == crc_reg) ? fpr_pkg::ST_OK
                                                                          : fpr_pkg::ST_BAD_CRC;
                end
                default: ;
            endcase
        end
    end

    // two-entry output: skid entry fills only while the head result is stalled
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (m_pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = res;
                out_valid_next = push;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= fpr_pkg::PH_HEADER;
            cnt_reg        <= '0;
            crc_reg        <= '0;
            first_reg      <= '0;
            hdr_lo_reg     <= '0;
            len_reg        <= '0;
            rw_reg         <= 1'b0;
            crc_lo_reg     <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            crc_reg        <= crc_next;
            first_reg      <= first_next;
            hdr_lo_reg     <= hdr_lo_next;
            len_reg        <= len_next;
            rw_reg         <= rw_next;
            crc_lo_reg     <= crc_lo_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (push && out_valid_reg && !m_pop) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {3'd0, out_reg.write_flag, out_reg.frame_length,
                       out_reg.frame_status, out_reg.payload_byte};

    a_skid_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty head");

    a_hdr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == fpr_pkg::PH_HEADER) |-> (cnt_reg <= LW'(fpr_pkg::HdrLastByte)))
        else $error("header byte count out of range");

    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == fpr_pkg::PH_PAYLOAD) |-> (len_reg != '0 && cnt_reg < len_reg))
        else $error("payload count beyond frame length");

    a_payload_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == fpr_pkg::KIND_PAYLOAD) |-> (m_tdata[9:8] == fpr_pkg::ST_OK))
        else $error("payload result carries a status");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled head result changed");

endmodule
